[sv/pcl_pkg.sv]
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared constants, codes and controller/datapath interface types for the
// path clearance lookup.
// ----------------------------------------------------------------------------
package pcl_pkg;

   // default sizing of the clearance table
   localparam int PCL_MAX_DECIMATED_PATHS = 64;
   localparam int PCL_ENTRIES_PER_PATH    = 16;

   // field widths
   localparam int PCL_INDEX_W  = 16;
   localparam int PCL_SLOT_W   = 4;
   localparam int PCL_VALUE_W  = 16;
   localparam int PCL_DCOUNT_W = 7;
   localparam int PCL_RATIO_W  = 17;
   localparam int PCL_PROD_W   = PCL_INDEX_W + PCL_RATIO_W;
   localparam int PCL_KFULL_W  = PCL_PROD_W + 1 - 16;

   // half an lsb of the Q.16 product, for round to nearest
   localparam logic [PCL_PROD_W:0] PCL_ROUND_HALF = (PCL_PROD_W + 1)'(32'h0000_8000);

   // configuration port
   localparam int PCL_ADDR_W = 4;
   localparam int PCL_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ACTUAL_PATH_COUNT    = 2'd0,
      REG_DECIMATED_PATH_COUNT = 2'd1,
      REG_INDEX_RATIO          = 2'd2
   } pcl_reg_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } pcl_req_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_RANGE      = 2'd1,
      STAT_EMPTY      = 2'd2,
      STAT_NO_ENTRIES = 2'd3
   } pcl_result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_CHECK,
      ST_CNT_READ,
      ST_CNT_CHECK,
      ST_FILL,
      ST_WALK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } pcl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_write;
      logic clear_step;
      logic mul;
      logic check;
      logic cnt_check;
      logic fill;
      logic walk;
      logic div_start;
      logic emit;
   } pcl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_load;
      logic clear_last;
      logic check_err;
      logic no_entries;
      logic walk_last;
      logic div_busy;
      logic out_free;
   } pcl_stat_type;

endpackage

[sv/pcl_div.sv]
// ----------------------------------------------------------------------------
// pcl_div
// Restoring divider, one quotient bit per cycle, for the clearance average.
// ----------------------------------------------------------------------------
module pcl_div import pcl_pkg::*; #(
   parameter int SUM_W = 21,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             busy,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W:0]    rem_shift;
   logic              fits;

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = (rem_shift >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[CNT_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[sv/pcl_datapath.sv]
// ----------------------------------------------------------------------------
// pcl_datapath
// Table memories, index mapping, entry walk, averaging and result register.
// ----------------------------------------------------------------------------
module pcl_datapath import pcl_pkg::*; #(
   parameter int MAX_DECIMATED_PATHS = PCL_MAX_DECIMATED_PATHS,
   parameter int ENTRIES_PER_PATH    = PCL_ENTRIES_PER_PATH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_type,
   input  logic [PCL_INDEX_W-1:0]  req_path_index,
   input  logic [PCL_SLOT_W-1:0]   req_slot,
   input  logic [PCL_VALUE_W-1:0]  req_distance,
   input  logic [PCL_VALUE_W-1:0]  req_clearance_in,
   input  logic                    req_integrate,
   input  logic [PCL_INDEX_W-1:0]  actual_path_count,
   input  logic [PCL_DCOUNT_W-1:0] decimated_path_count,
   input  logic [PCL_RATIO_W-1:0]  index_ratio,
   input  pcl_cmd_type             cmd,
   output pcl_stat_type            stat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PCL_VALUE_W-1:0]  rsp_clearance_out,
   output logic [1:0]              rsp_status
);

   localparam int PATH_W    = (MAX_DECIMATED_PATHS > 1) ? $clog2(MAX_DECIMATED_PATHS) : 1;
   localparam int SLOT_W    = (ENTRIES_PER_PATH > 1) ? $clog2(ENTRIES_PER_PATH) : 1;
   localparam int CNT_W     = $clog2(ENTRIES_PER_PATH + 1);
   localparam int SUM_W     = PCL_VALUE_W + CNT_W;
   localparam int MEM_DEPTH = 2 ** (PATH_W + SLOT_W);

   // memories
   logic [PCL_VALUE_W-1:0] dist_mem [MEM_DEPTH];
   logic [PCL_VALUE_W-1:0] clr_mem  [MEM_DEPTH];
   logic [CNT_W-1:0]       cnt_mem  [MAX_DECIMATED_PATHS];

   // captured word
   logic                   type_ff;
   logic [PCL_INDEX_W-1:0] pidx_ff;
   logic [PCL_SLOT_W-1:0]  slot_ff;
   logic [PCL_VALUE_W-1:0] dist_ff;
   logic [PCL_VALUE_W-1:0] clrin_ff;
   logic                   integ_ff;

   // query working registers
   logic [PCL_PROD_W-1:0]  prod_ff;
   logic [PATH_W-1:0]      k_ff;
   logic [CNT_W-1:0]       cnt_rd_ff;
   logic [CNT_W-1:0]       n_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [PCL_VALUE_W-1:0] dist_rd_ff;
   logic [PCL_VALUE_W-1:0] clr_rd_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       acc_cnt_ff, acc_cnt_in;
   pcl_result_type         res_ff;
   logic [PATH_W-1:0]      clear_idx_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [PCL_VALUE_W-1:0] rsp_clr_ff;
   logic [1:0]             rsp_status_ff;

   logic                    load_ok;
   logic [PCL_SLOT_W:0]     slot_p1;
   logic [PATH_W+SLOT_W-1:0] wr_addr;
   logic [PATH_W+SLOT_W-1:0] rd_addr;
   logic [PCL_PROD_W:0]     round_sum;
   logic [PCL_KFULL_W-1:0]  k_full;
   pcl_result_type          chk_res;
   logic [CNT_W-1:0]        n_in;
   logic                    div_busy;
   logic [SUM_W-1:0]        quotient;

   assign load_ok = (pidx_ff < MAX_DECIMATED_PATHS) && (slot_ff < ENTRIES_PER_PATH);
   assign slot_p1 = {1'b0, slot_ff} + 1'b1;
   assign wr_addr = {PATH_W'(pidx_ff), SLOT_W'(slot_ff)};
   assign rd_addr = {k_ff, idx_ff[SLOT_W-1:0]};

   // decimated index k = round(index * ratio)
   assign round_sum = {1'b0, prod_ff} + PCL_ROUND_HALF;
   assign k_full    = round_sum[PCL_PROD_W:16];

   always_comb begin
      if (decimated_path_count == '0) begin
         chk_res = STAT_EMPTY;
      end else if (pidx_ff >= actual_path_count) begin
         chk_res = STAT_RANGE;
      end else if ((k_full >= {(PCL_KFULL_W - PCL_DCOUNT_W)'(0), decimated_path_count})
                   || (k_full >= PCL_KFULL_W'(MAX_DECIMATED_PATHS))) begin
         chk_res = STAT_RANGE;
      end else begin
         chk_res = STAT_OK;
      end
   end

   assign n_in = (cnt_rd_ff > CNT_W'(ENTRIES_PER_PATH)) ? CNT_W'(ENTRIES_PER_PATH) : cnt_rd_ff;

   // integrate off restarts the sum on every entry
   always_comb begin
      if (integ_ff) begin
         sum_in     = sum_ff + SUM_W'(clr_rd_ff);
         acc_cnt_in = acc_cnt_ff + 1'b1;
      end else begin
         sum_in     = SUM_W'(clr_rd_ff);
         acc_cnt_in = CNT_W'(1);
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.load_write && load_ok) begin
         dist_mem[wr_addr] <= dist_ff;
         clr_mem[wr_addr]  <= clrin_ff;
      end
      dist_rd_ff <= dist_mem[rd_addr];
      clr_rd_ff  <= clr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         cnt_mem[clear_idx_ff] <= '0;
      end else if (cmd.load_write && load_ok) begin
         cnt_mem[PATH_W'(pidx_ff)] <= CNT_W'(slot_p1);
      end
      cnt_rd_ff <= cnt_mem[k_ff];
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         pidx_ff  <= req_path_index;
         slot_ff  <= req_slot;
         dist_ff  <= req_distance;
         clrin_ff <= req_clearance_in;
         integ_ff <= req_integrate;
      end
      if (cmd.mul) begin
         prod_ff <= {(PCL_PROD_W - PCL_INDEX_W)'(0), pidx_ff}
                  * {(PCL_PROD_W - PCL_RATIO_W)'(0), index_ratio};
      end
      if (cmd.check) begin
         k_ff   <= k_full[PATH_W-1:0];
         res_ff <= chk_res;
      end
      if (cmd.cnt_check) begin
         n_ff       <= n_in;
         idx_ff     <= '0;
         sum_ff     <= '0;
         acc_cnt_ff <= '0;
         if (n_in == '0) begin
            res_ff <= STAT_NO_ENTRIES;
         end
      end
      if (cmd.fill) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.walk) begin
         idx_ff     <= idx_ff + 1'b1;
         sum_ff     <= sum_in;
         acc_cnt_ff <= acc_cnt_in;
      end
   end

   pcl_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (acc_cnt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_clr_ff    <= (res_ff == STAT_OK) ? quotient[PCL_VALUE_W-1:0] : '0;
         rsp_status_ff <= res_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clearance_out = rsp_clr_ff;
   assign rsp_status        = rsp_status_ff;

   always_comb begin
      stat.req_is_load = (type_ff == REQ_LOAD);
      stat.clear_last  = (clear_idx_ff == PATH_W'(MAX_DECIMATED_PATHS - 1));
      stat.check_err   = (chk_res != STAT_OK);
      stat.no_entries  = (n_in == '0);
      // stop at the last stored entry or the first one beyond the query distance
      stat.walk_last   = (idx_ff == n_ff) || (dist_rd_ff > dist_ff);
      stat.div_busy    = div_busy;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

[sv/pcl_ctrl.sv]
// ----------------------------------------------------------------------------
// pcl_ctrl
// Sequencer for table clearing, loads and clearance queries.
// ----------------------------------------------------------------------------
module pcl_ctrl import pcl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pcl_stat_type stat,
   output pcl_cmd_type  cmd
);

   pcl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // captured word decides load or query
            if (stat.req_is_load) begin
               cmd.load_write = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.check_err ? ST_EMIT : ST_CNT_READ;
         end
         ST_CNT_READ: begin
            state_in = ST_CNT_CHECK;
         end
         ST_CNT_CHECK: begin
            cmd.cnt_check = 1'b1;
            state_in      = stat.no_entries ? ST_EMIT : ST_FILL;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!stat.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/path_clearance_lookup.sv]
// ----------------------------------------------------------------------------
// path_clearance_lookup
// Per-path clearance table with averaged lookup by actual path index.
// ----------------------------------------------------------------------------
// After reset the block sweeps the per-path entry counts to zero, one path per
// cycle, and holds req_stall high meanwhile; the csr port works throughout.
// Words are taken one at a time. A query that hits a range or empty-table
// check, or a path with no entries, answers without a walk; otherwise it
// walks the entries (one entry per cycle out of the table memory), and a
// one-bit-per-cycle divider then forms the average. A finished result waits
// in an output register, so the next word is taken while it is still stalled.
module path_clearance_lookup import pcl_pkg::*; #(
   parameter int MAX_DECIMATED_PATHS = PCL_MAX_DECIMATED_PATHS,
   parameter int ENTRIES_PER_PATH    = PCL_ENTRIES_PER_PATH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_type,
   input  logic [PCL_INDEX_W-1:0] req_path_index,
   input  logic [PCL_SLOT_W-1:0]  req_slot,
   input  logic [PCL_VALUE_W-1:0] req_distance,
   input  logic [PCL_VALUE_W-1:0] req_clearance_in,
   input  logic                   req_integrate,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PCL_VALUE_W-1:0] rsp_clearance_out,
   output logic [1:0]             rsp_status,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [PCL_ADDR_W-1:0]  csr_paddr,
   input  logic [PCL_DATA_W-1:0]  csr_pwdata,
   output logic [PCL_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [PCL_INDEX_W-1:0]  actual_count_ff;
   logic [PCL_DCOUNT_W-1:0] dec_count_ff;
   logic [PCL_RATIO_W-1:0]  ratio_ff;
   logic                    csr_write;
   pcl_reg_type             csr_index;
   pcl_cmd_type             cmd;
   pcl_stat_type            stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pcl_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         actual_count_ff <= '0;
         dec_count_ff    <= '0;
         ratio_ff        <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ACTUAL_PATH_COUNT:    actual_count_ff <= csr_pwdata[PCL_INDEX_W-1:0];
            REG_DECIMATED_PATH_COUNT: dec_count_ff    <= csr_pwdata[PCL_DCOUNT_W-1:0];
            REG_INDEX_RATIO:          ratio_ff        <= csr_pwdata[PCL_RATIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ACTUAL_PATH_COUNT:    csr_prdata = PCL_DATA_W'(actual_count_ff);
         REG_DECIMATED_PATH_COUNT: csr_prdata = PCL_DATA_W'(dec_count_ff);
         REG_INDEX_RATIO:          csr_prdata = PCL_DATA_W'(ratio_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   pcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcl_datapath #(
      .MAX_DECIMATED_PATHS (MAX_DECIMATED_PATHS),
      .ENTRIES_PER_PATH    (ENTRIES_PER_PATH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_type             (req_type),
      .req_path_index       (req_path_index),
      .req_slot             (req_slot),
      .req_distance         (req_distance),
      .req_clearance_in     (req_clearance_in),
      .req_integrate        (req_integrate),
      .actual_path_count    (actual_count_ff),
      .decimated_path_count (dec_count_ff),
      .index_ratio          (ratio_ff),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clearance_out    (rsp_clearance_out),
      .rsp_status           (rsp_status)
   );

endmodule

[verif/path_clearance_lookup_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_clearance_lookup_test
// Self-checking bench for the path clearance lookup. A short directed table
// covers reset behavior, range errors, empty paths and edge values. Random
// phases then fill decimated paths with sorted entries and query them under
// a range of register settings. Every query answer is checked against a local
// model of the table or a fixed expected answer, with random stalls on both channels.
// ----------------------------------------------------------------------------
module path_clearance_lookup_test;
   import pcl_pkg::*;

   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [PCL_VALUE_W-1:0] clearance;
      pcl_result_type         status;
   } answer_type;

   typedef struct {
      pcl_req_type            kind;
      logic [PCL_INDEX_W-1:0] path;
      logic [PCL_SLOT_W-1:0]  slot;
      logic [PCL_VALUE_W-1:0] distance;
      logic [PCL_VALUE_W-1:0] clr;
      logic                   integ;
      bit                     fixed;
      answer_type             answer;
   } word_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_type = REQ_LOAD;
   logic [PCL_INDEX_W-1:0] req_path_index = '0;
   logic [PCL_SLOT_W-1:0]  req_slot = '0;
   logic [PCL_VALUE_W-1:0] req_distance = '0;
   logic [PCL_VALUE_W-1:0] req_clearance_in = '0;
   logic                   req_integrate = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PCL_VALUE_W-1:0] rsp_clearance_out;
   logic [1:0]             rsp_status;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [PCL_ADDR_W-1:0]  csr_paddr = '0;
   logic [PCL_DATA_W-1:0]  csr_pwdata = '0;
   logic [PCL_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // local copy of the registers and the clearance table
   logic [15:0]            cfg_actual = '0;
   logic [PCL_DCOUNT_W-1:0] cfg_decimated = '0;
   logic [PCL_RATIO_W-1:0] cfg_ratio = '0;
   logic [4:0]             path_len [PCL_MAX_DECIMATED_PATHS] = '{default: '0};
   logic [15:0]            path_dist [PCL_MAX_DECIMATED_PATHS][PCL_ENTRIES_PER_PATH];
   logic [15:0]            path_clr [PCL_MAX_DECIMATED_PATHS][PCL_ENTRIES_PER_PATH];
   logic [PCL_ENTRIES_PER_PATH-1:0] slot_written [PCL_MAX_DECIMATED_PATHS] =
      '{default: '0};

   answer_type  pending_answers[$];
   int          errors = 0;
   int          n_loads = 0;
   int          n_queries = 0;
   int          n_results = 0;
   int          n_settings = 0;
   int          status_seen [4] = '{default: 0};
   logic        no_gaps = 1'b0;
   int unsigned hold_token = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   path_clearance_lookup dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic word_type make_row(pcl_req_type kind, int path, int slot,
                                         int distance, int clr, bit integ,
                                         bit fixed = 1'b0,
                                         pcl_result_type st = STAT_OK, int ans = 0);
      word_type w;
      w.kind = kind;
      w.path = 16'(path);
      w.slot = 4'(slot);
      w.distance = 16'(distance);
      w.clr = 16'(clr);
      w.integ = integ;
      w.fixed = fixed;
      w.answer.clearance = 16'(ans);
      w.answer.status = st;
      return w;
   endfunction

   function automatic void store_entry(logic [15:0] path, logic [3:0] slot,
                                       logic [15:0] distance, logic [15:0] clr);
      if (path < PCL_MAX_DECIMATED_PATHS) begin
         path_dist[path][slot] = distance;
         path_clr[path][slot] = clr;
         path_len[path] = 5'(slot) + 5'd1;
         slot_written[path][slot] = 1'b1;
      end
   endfunction

   function automatic answer_type lookup_clearance(logic [15:0] idx, logic [15:0] distance,
                                                   logic integ);
      answer_type a;
      logic [33:0] k;
      int sum, cnt, n, i;
      a.clearance = '0;
      a.status = STAT_OK;
      if (cfg_decimated == 0)
         a.status = STAT_EMPTY;
      else if (idx >= cfg_actual)
         a.status = STAT_RANGE;
      else begin
         k = (34'(idx) * 34'(cfg_ratio) + 34'h8000) >> 16;
         if (k >= 34'(cfg_decimated) || k >= 34'(PCL_MAX_DECIMATED_PATHS))
            a.status = STAT_RANGE;
         else begin
            n = path_len[k[5:0]];
            if (n == 0)
               a.status = STAT_NO_ENTRIES;
            else begin
               sum = 0;
               cnt = 0;
               for (i = 0; i < n; i++) begin
                  // without integrate only the last entry walked counts
                  if (!integ) begin
                     sum = 0;
                     cnt = 0;
                  end
                  sum += path_clr[k[5:0]][i];
                  cnt++;
                  if (path_dist[k[5:0]][i] > distance)
                     break;
               end
               a.clearance = 16'(sum / cnt);
            end
         end
      end
      return a;
   endfunction

   // slots at or below this count can be loaded without leaving a hole
   function automatic int written_prefix(int p);
      int s;
      s = 0;
      while (s < PCL_ENTRIES_PER_PATH && slot_written[p][s])
         s++;
      return s;
   endfunction

   function automatic int ratio_for(int act, int dec);
      longint r;
      if (act < 2)
         return 0;
      r = ((longint'(dec - 1) << 16) + (act - 1) / 2) / (act - 1);
      return (r > 32'h1FFFF) ? 32'h1FFFF : int'(r);
   endfunction

   // actual index whose rounded mapping lands on decimated path p
   function automatic int aim_index(int p);
      longint v;
      if (cfg_ratio == 0)
         return 0;
      v = ((longint'(p) << 16) + cfg_ratio / 2) / cfg_ratio;
      return (v > 16'hFFFF) ? 16'hFFFF : int'(v);
   endfunction

   function automatic int pick_path();
      if (cfg_decimated != 0 && cfg_decimated <= PCL_MAX_DECIMATED_PATHS &&
          $urandom_range(9) != 0)
         return $urandom_range(0, cfg_decimated - 1);
      return $urandom_range(0, PCL_MAX_DECIMATED_PATHS - 1);
   endfunction

   function automatic int pick_clearance();
      return ($urandom_range(9) == 0) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
   endfunction

   task automatic send_word(input word_type w);
      if (!no_gaps && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= w.kind;
      req_path_index <= w.path;
      req_slot <= w.slot;
      req_distance <= w.distance;
      req_clearance_in <= w.clr;
      req_integrate <= w.integ;
      do @(posedge clock); while (req_stall);
      if (w.kind == REQ_LOAD) begin
         store_entry(w.path, w.slot, w.distance, w.clr);
         n_loads++;
      end else begin
         pending_answers.push_back(w.fixed ? w.answer :
                                   lookup_clearance(w.path, w.distance, w.integ));
         n_queries++;
      end
   endtask

   // wait for every answer, then give a trailing load time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(pcl_reg_type r, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic csr_check(pcl_reg_type r, logic [31:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {r, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: register %s read expected %h got %h", $time, r.name(), want,
                  csr_prdata);
         errors++;
      end
   endtask

   task automatic configure(int act, int dec, int ratio);
      settle();
      csr_write(REG_ACTUAL_PATH_COUNT, 32'(act));
      csr_write(REG_DECIMATED_PATH_COUNT, 32'(dec));
      csr_write(REG_INDEX_RATIO, 32'(ratio));
      csr_check(REG_ACTUAL_PATH_COUNT, 32'(act) & 32'hFFFF);
      csr_check(REG_DECIMATED_PATH_COUNT, 32'(dec) & 32'h7F);
      csr_check(REG_INDEX_RATIO, 32'(ratio) & 32'h1FFFF);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      cfg_actual = 16'(act);
      cfg_decimated = 7'(dec);
      cfg_ratio = 17'(ratio);
      n_settings++;
   endtask

   task automatic run_phase(int unsigned quota);
      int unsigned done_words;
      int roll, p, len, d, s, nq, idx, qdist, j;
      done_words = 0;
      while (done_words < quota) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            // fill one path in distance order, then ask about it
            p = pick_path();
            len = ($urandom_range(9) == 0) ? PCL_ENTRIES_PER_PATH : $urandom_range(1, 6);
            d = $urandom_range(0, 16'h2000);
            for (s = 0; s < len; s++) begin
               if (s != 0)
                  d += $urandom_range(0, 16'h2000);
               if (d > 16'hFFFF)
                  d = 16'hFFFF;
               send_word(make_row(REQ_LOAD, p, s, d, pick_clearance(), $urandom_range(1)));
            end
            nq = $urandom_range(1, 4);
            for (j = 0; j < nq; j++) begin
               roll = $urandom_range(99);
               if (roll < 60 && cfg_ratio != 0)
                  idx = aim_index(p);
               else if (roll < 90 && cfg_actual != 0)
                  idx = $urandom_range(0, cfg_actual - 1);
               else
                  idx = $urandom_range(0, 16'hFFFF);
               // landing exactly on a stored distance probes the strict compare
               qdist = ($urandom_range(2) == 0) ? path_dist[p][$urandom_range(0, len - 1)]
                                                : $urandom_range(0, 16'hFFFF);
               send_word(make_row(REQ_QUERY, idx, $urandom_range(15), qdist,
                                  $urandom_range(0, 16'hFFFF), $urandom_range(1)));
            end
            done_words += len + nq;
         end else if (roll < 85) begin
            if ($urandom_range(2) == 0)
               send_word(make_row(REQ_LOAD, $urandom_range(PCL_MAX_DECIMATED_PATHS, 16'hFFFF),
                                  $urandom_range(15), $urandom_range(0, 16'hFFFF),
                                  $urandom_range(0, 16'hFFFF), $urandom_range(1)));
            else begin
               // out-of-order rewrite of an already reachable slot
               p = $urandom_range(0, PCL_MAX_DECIMATED_PATHS - 1);
               s = written_prefix(p);
               if (s > PCL_ENTRIES_PER_PATH - 1)
                  s = PCL_ENTRIES_PER_PATH - 1;
               send_word(make_row(REQ_LOAD, p, $urandom_range(0, s),
                                  $urandom_range(0, 16'hFFFF), pick_clearance(),
                                  $urandom_range(1)));
               done_words++;
            end
         end else begin
            send_word(make_row(REQ_QUERY, $urandom_range(0, 16'hFFFF), $urandom_range(15),
                               $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                               $urandom_range(1)));
            done_words++;
         end
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= !no_gaps && ($urandom_range(99) < 27);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         status_seen[int'(rsp_status)]++;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected word, clearance %h status %0d", $time,
                     rsp_clearance_out, rsp_status);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_clearance_out !== want.clearance) begin
               $display("%0t: clearance_out expected %h got %h", $time, want.clearance,
                        rsp_clearance_out);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      word_type plan[$];
      int act, dec;

      // empty table right after reset
      plan.push_back(make_row(REQ_QUERY, 0, 0, 0, 0, 1, 1, STAT_EMPTY, 0));
      // from here on: 8 actual paths onto 4 decimated, ratio one
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'hFFFF, 0, 1, 1, STAT_NO_ENTRIES, 0));
      plan.push_back(make_row(REQ_QUERY, 8, 0, 0, 0, 1, 1, STAT_RANGE, 0));
      plan.push_back(make_row(REQ_QUERY, 5, 0, 0, 0, 0, 1, STAT_RANGE, 0));
      plan.push_back(make_row(REQ_QUERY, 16'hFFFF, 15, 16'hFFFF, 16'hFFFF, 1, 1,
                              STAT_RANGE, 0));
      plan.push_back(make_row(REQ_LOAD, 0, 0, 16'h1000, 16'hFFFF, 0));
      plan.push_back(make_row(REQ_LOAD, 0, 1, 16'h2000, 16'h0000, 0));
      plan.push_back(make_row(REQ_LOAD, 0, 2, 16'h8000, 16'h8000, 1));
      plan.push_back(make_row(REQ_LOAD, 0, 3, 16'hFFFF, 16'hFFFF, 0));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'h0000, 0, 1));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'hFFFF, 0, 1));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'h1800, 0, 0));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'hFFFF, 0, 0));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'h2000, 0, 1));
      // distances out of order in path 1
      plan.push_back(make_row(REQ_LOAD, 1, 0, 16'h9000, 16'h1234, 0));
      plan.push_back(make_row(REQ_LOAD, 1, 1, 16'h0100, 16'h4321, 0));
      plan.push_back(make_row(REQ_QUERY, 1, 0, 16'h0200, 0, 1));
      plan.push_back(make_row(REQ_LOAD, PCL_MAX_DECIMATED_PATHS - 1, 0, 16'h5555,
                              16'hAAAA, 1));
      // loads past the last path are dropped
      plan.push_back(make_row(REQ_LOAD, PCL_MAX_DECIMATED_PATHS, 15, 16'h0001, 16'h0001, 0));
      plan.push_back(make_row(REQ_LOAD, 16'hFFFF, 15, 16'hFFFF, 16'hFFFF, 1));
      // rewriting slot 0 shortens path 0 to one entry
      plan.push_back(make_row(REQ_LOAD, 0, 0, 16'h7FFF, 16'h0001, 0));
      plan.push_back(make_row(REQ_QUERY, 0, 0, 16'h7FFF, 0, 1));
      plan.push_back(make_row(REQ_QUERY, 3, 0, 16'h4000, 0, 0, 1, STAT_NO_ENTRIES, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (i == 1)
            configure(8, 4, 65536);
         send_word(plan[i]);
      end

      configure(64, 64, 65536);
      run_phase(20);
      hold_token <= hold_token + 1;
      run_phase(80);
      configure(65535, 64, ratio_for(65535, 64));
      run_phase(100);
      configure(200, 50, ratio_for(200, 50));
      run_phase(45);
      settle();
      run_phase(45);
      no_gaps <= 1'b1;
      configure(16, 8, ratio_for(16, 8));
      run_phase(100);
      no_gaps <= 1'b0;
      configure(128, 127, 65536);
      run_phase(70);
      configure(64, 64, 17'h1FFFF);
      run_phase(70);
      configure(0, 64, 65536);
      run_phase(30);
      configure(100, 0, 65536);
      run_phase(30);
      configure(1, 1, 0);
      run_phase(40);
      act = $urandom_range(2, 300);
      dec = $urandom_range(1, PCL_MAX_DECIMATED_PATHS);
      configure(act, dec, ratio_for(act, dec));
      run_phase(100);
      settle();

      $display("covered %0d loads and %0d queries over %0d register settings, %0d answers",
               n_loads, n_queries, n_settings, n_results);
      $display("answer status mix: ok %0d, range %0d, empty %0d, no entries %0d",
               status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_EMPTY],
               status_seen[STAT_NO_ENTRIES]);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
